[rtl/core/dnsarp_pkg.sv]
// Shared types and constants for the DNS response A-record parser.
// No dependencies; imported by dnsarp_parser and the top level.
`timescale 1ns / 1ps

package dnsarp_pkg;

  localparam int OFF_W   = 10;  // byte offset counter width
  localparam int STEP_W  = 7;   // name step counter width
  localparam int ANS_W   = 5;   // answers seen counter width
  localparam int WORD_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int STAT_W  = 3;

  localparam logic [7:0] PTR_MASK = 8'hC0;
  localparam logic [3:0] HDR_LAST = 4'd11;  // final header offset

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_RESP = 3'd2,
    ST_RCODE    = 3'd3,
    ST_NO_ANS   = 3'd4,
    ST_BAD_NAME = 3'd5,
    ST_NO_A     = 3'd6
  } status_t;

  typedef enum logic [10:0] {
    PH_HDR    = 11'b000_0000_0001,
    PH_QNAME  = 11'b000_0000_0010,
    PH_QLABEL = 11'b000_0000_0100,
    PH_QPTR   = 11'b000_0000_1000,
    PH_QTAIL  = 11'b000_0001_0000,
    PH_ANAME  = 11'b000_0010_0000,
    PH_ALABEL = 11'b000_0100_0000,
    PH_APTR   = 11'b000_1000_0000,
    PH_AFIX   = 11'b001_0000_0000,
    PH_AADDR  = 11'b010_0000_0000,
    PH_ASKIP  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   ip_address;
  } result_t;

endpackage

[rtl/core/dnsarp_parser.sv]
// Per-byte parse state machine: header checks, name skipping, answer scan.
// Depends on dnsarp_pkg. Result is combinational, registered by the top level.
`timescale 1ns / 1ps

module dnsarp_parser #(
  parameter int MAX_PACKET      = 512,
  parameter int MAX_ANSWERS     = 16,
  parameter int NAME_STEP_LIMIT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                word_en,
  input  logic [7:0]          word_byte,
  input  logic                word_last,
  output dnsarp_pkg::result_t res
);
  import dnsarp_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic                qr_r, qr_nxt;
  logic [3:0]          rcode_r, rcode_nxt;
  logic [WORD_W-1:0]   ans_total_r, ans_total_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic [WORD_W-1:0]   skip_r, skip_nxt;
  logic [ANS_W-1:0]    seen_r, seen_nxt;
  logic [WORD_W-1:0]   rtype_r, rtype_nxt;
  logic [WORD_W-1:0]   rlen_r, rlen_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  status_t             fstat_r, fstat_nxt;
  logic                decided_r, decided_nxt;

  logic [WORD_W-1:0]   skip_dec;
  logic                ans_exhausted;
  logic                q_side;
  status_t             out_status;

  assign skip_dec = skip_r - WORD_W'(1);
  assign ans_exhausted = ({{(WORD_W-ANS_W){1'b0}}, seen_r} >= ans_total_r) ||
                         (seen_r >= ANS_W'(MAX_ANSWERS));

  always_comb begin
    phase_nxt     = phase_r;
    off_nxt       = off_r;
    qr_nxt        = qr_r;
    rcode_nxt     = rcode_r;
    ans_total_nxt = ans_total_r;
    steps_nxt     = steps_r;
    skip_nxt      = skip_r;
    seen_nxt      = seen_r;
    rtype_nxt     = rtype_r;
    rlen_nxt      = rlen_r;
    addr_nxt      = addr_r;
    fstat_nxt     = fstat_r;
    decided_nxt   = decided_r;

    if (off_r < OFF_W'(MAX_PACKET)) begin
      off_nxt = off_r + OFF_W'(1);
      if (!decided_r) begin
        unique case (phase_r)
          PH_HDR: begin
            case (off_r)
              OFF_W'(2): qr_nxt = word_byte[7];
              OFF_W'(3): rcode_nxt = word_byte[3:0];
              OFF_W'(6): ans_total_nxt = {word_byte, 8'h00};
              OFF_W'(7): ans_total_nxt = {ans_total_r[15:8], word_byte};
              OFF_W'(HDR_LAST): begin
                if (!qr_r) begin
                  decided_nxt = 1'b1;
                  fstat_nxt   = ST_NOT_RESP;
                end else if (rcode_r != 4'd0) begin
                  decided_nxt = 1'b1;
                  fstat_nxt   = ST_RCODE;
                end else if (ans_total_r == '0) begin
                  decided_nxt = 1'b1;
                  fstat_nxt   = ST_NO_ANS;
                end else begin
                  phase_nxt = PH_QNAME;
                  steps_nxt = '0;
                end
              end
              default: ;
            endcase
          end
          PH_QNAME, PH_ANAME: begin
            if (steps_r > STEP_W'(NAME_STEP_LIMIT)) begin
              decided_nxt = 1'b1;
              fstat_nxt   = (phase_r == PH_QNAME) ? ST_BAD_NAME : ST_NO_A;
            end else begin
              steps_nxt = steps_r + STEP_W'(1);
              if (word_byte == 8'h00) begin
                if (phase_r == PH_QNAME) begin
                  phase_nxt = PH_QTAIL;
                  skip_nxt  = WORD_W'(4);
                end else begin
                  phase_nxt = PH_AFIX;
                  skip_nxt  = WORD_W'(10);
                  rtype_nxt = '0;
                  rlen_nxt  = '0;
                end
              end else if ((word_byte & PTR_MASK) == PTR_MASK) begin
                phase_nxt = (phase_r == PH_QNAME) ? PH_QPTR : PH_APTR;
              end else if ((word_byte & PTR_MASK) != 8'h00) begin
                decided_nxt = 1'b1;
                fstat_nxt   = (phase_r == PH_QNAME) ? ST_BAD_NAME : ST_NO_A;
              end else begin
                skip_nxt  = {8'h00, word_byte};
                phase_nxt = (phase_r == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
              end
            end
          end
          PH_QLABEL, PH_ALABEL: begin
            skip_nxt = skip_dec;
            if (skip_dec == '0)
              phase_nxt = (phase_r == PH_QLABEL) ? PH_QNAME : PH_ANAME;
          end
          PH_QPTR: begin
            phase_nxt = PH_QTAIL;
            skip_nxt  = WORD_W'(4);
          end
          PH_APTR: begin
            phase_nxt = PH_AFIX;
            skip_nxt  = WORD_W'(10);
            rtype_nxt = '0;
            rlen_nxt  = '0;
          end
          PH_QTAIL, PH_ASKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              if (ans_exhausted) begin
                decided_nxt = 1'b1;
                fstat_nxt   = ST_NO_A;
              end else begin
                seen_nxt  = seen_r + ANS_W'(1);
                steps_nxt = '0;
                phase_nxt = PH_ANAME;
              end
            end
          end
          PH_AFIX: begin
            // fixed part: type(2) class(2) ttl(4) rdlength(2); skip counts 10..1
            case (skip_r)
              WORD_W'(10): rtype_nxt = {word_byte, 8'h00};
              WORD_W'(9):  rtype_nxt = {rtype_r[15:8], word_byte};
              WORD_W'(2):  rlen_nxt  = {word_byte, 8'h00};
              WORD_W'(1):  rlen_nxt  = {rlen_r[15:8], word_byte};
              default: ;
            endcase
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              if (rtype_r == WORD_W'(1) && rlen_nxt == WORD_W'(4)) begin
                phase_nxt = PH_AADDR;
                skip_nxt  = WORD_W'(4);
                addr_nxt  = '0;
              end else if (rlen_nxt == '0) begin
                if (ans_exhausted) begin
                  decided_nxt = 1'b1;
                  fstat_nxt   = ST_NO_A;
                end else begin
                  seen_nxt  = seen_r + ANS_W'(1);
                  steps_nxt = '0;
                  phase_nxt = PH_ANAME;
                end
              end else begin
                skip_nxt  = rlen_nxt;
                phase_nxt = PH_ASKIP;
              end
            end
          end
          PH_AADDR: begin
            addr_nxt = {addr_r[23:0], word_byte};
            skip_nxt = skip_dec;
            if (skip_dec == '0) begin
              decided_nxt = 1'b1;
              fstat_nxt   = ST_FOUND;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign q_side = (phase_nxt == PH_QNAME) || (phase_nxt == PH_QLABEL) ||
                  (phase_nxt == PH_QPTR) || (phase_nxt == PH_QTAIL);

  always_comb begin
    if (decided_nxt)
      out_status = fstat_nxt;
    else if (phase_nxt == PH_HDR)
      out_status = ST_SHORT;
    else if (q_side)
      out_status = ST_BAD_NAME;
    else
      out_status = ST_NO_A;
    res.status     = out_status;
    res.ip_address = (out_status == ST_FOUND) ? addr_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (word_en && word_last)) begin
      phase_r     <= PH_HDR;
      off_r       <= '0;
      qr_r        <= 1'b0;
      rcode_r     <= '0;
      ans_total_r <= '0;
      steps_r     <= '0;
      skip_r      <= '0;
      seen_r      <= '0;
      rtype_r     <= '0;
      rlen_r      <= '0;
      addr_r      <= '0;
      fstat_r     <= ST_NO_A;
      decided_r   <= 1'b0;
    end else if (word_en) begin
      phase_r     <= phase_nxt;
      off_r       <= off_nxt;
      qr_r        <= qr_nxt;
      rcode_r     <= rcode_nxt;
      ans_total_r <= ans_total_nxt;
      steps_r     <= steps_nxt;
      skip_r      <= skip_nxt;
      seen_r      <= seen_nxt;
      rtype_r     <= rtype_nxt;
      rlen_r      <= rlen_nxt;
      addr_r      <= addr_nxt;
      fstat_r     <= fstat_nxt;
      decided_r   <= decided_nxt;
    end
  end

endmodule

[rtl/core/dns_response_a_record_parser_core.sv]
// Top level: input word register, parser state machine, result register.
// Depends on dnsarp_pkg and dnsarp_parser.
// out_valid comes from the result register, loaded when the last byte leaves the input register.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while the result register holds an untaken result.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the header phase.
`timescale 1ns / 1ps

module dns_response_a_record_parser_core #(
  parameter int MAX_PACKET      = 512,
  parameter int MAX_ANSWERS     = 16,
  parameter int NAME_STEP_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_ip_address
);
  import dnsarp_pkg::*;

  logic        word_v_r;
  logic [7:0]  word_byte_r;
  logic        word_last_r;
  logic        out_v_r;
  result_t     res_r;
  result_t     res;
  logic        out_busy;
  logic        word_en;

  assign out_busy = out_v_r && out_stall;
  // a last byte needs the result slot; other bytes never wait
  assign word_en  = word_v_r && !(word_last_r && out_busy);
  assign in_stall = word_v_r && word_last_r && out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      word_v_r <= 1'b1;
    end else if (word_en) begin
      word_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_byte_r <= in_packet_byte;
      word_last_r <= in_last_byte;
    end
  end

  dnsarp_parser #(
    .MAX_PACKET      (MAX_PACKET),
    .MAX_ANSWERS     (MAX_ANSWERS),
    .NAME_STEP_LIMIT (NAME_STEP_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_en   (word_en),
    .word_byte (word_byte_r),
    .word_last (word_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (word_en && word_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_en && word_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_status     = res_r.status;
  assign out_ip_address = res_r.ip_address;

endmodule

[test/dns_response_a_record_parser_core_tb.sv]
// Testbench for dns_response_a_record_parser_core: directed packet table, then random packets.
// Typed rows set the expected result, else an in-bench predictor; needs dnsarp_pkg, the core.
`timescale 1ns / 1ps

module dns_response_a_record_parser_core_tb;
  import dnsarp_pkg::*;

  localparam int MAX_PACKET      = 512;
  localparam int MAX_ANSWERS     = 16;
  localparam int NAME_STEP_LIMIT = 64;
  localparam int N_DIRECTED      = 27;
  localparam int RANDOM_WORDS    = 500;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_START      = 2000;
  localparam int HOLD_CYCLES     = 500;

  // how a name is written into a packet
  typedef enum logic [2:0] {NM_LABELS, NM_PTR, NM_RES01, NM_RES10} name_form_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [15:0] flags;
    logic [15:0] ancount;
    name_form_t  q_form;
    int          q_lab;     // labels ahead of the end/pointer/reserved byte
    int          lab_len;   // 0: random label lengths
    int          n_pre;     // non-A records ahead of the final record
    name_form_t  a_form;
    int          a_lab;
    logic [15:0] a_type;
    logic [15:0] a_len;
    logic [31:0] a_ip;
    int          n_post;    // A records after the final record
    int          trunc;     // keep this many bytes, 0: whole packet
    int          pad;       // filler bytes after the packet
    bit          typed;     // expected status given in the row
    status_t     exp_status;
  } pkt_spec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_ip_address;

  dns_response_a_record_parser_core #(
    .MAX_PACKET(MAX_PACKET),
    .MAX_ANSWERS(MAX_ANSWERS),
    .NAME_STEP_LIMIT(NAME_STEP_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_packet_byte(in_packet_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_ip_address(out_ip_address)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pkt_spec_t   dir_tab [N_DIRECTED];
  logic [7:0]  pkt [$];
  result_t     expected_lookups [$];
  result_t     head_lookup;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          live_words;

  // predictor state
  phase_t      pr_phase;
  logic [9:0]  pr_off;
  logic [15:0] pr_flags;
  logic [15:0] pr_ancount;
  logic [6:0]  pr_steps;
  logic [15:0] pr_skip;
  logic [4:0]  pr_seen;
  logic [15:0] pr_rtype;
  logic [15:0] pr_rlen;
  logic [31:0] pr_addr;
  status_t     pr_status;
  bit          pr_done;

  task automatic dns_reset_state();
    pr_phase   = PH_HDR;
    pr_off     = '0;
    pr_flags   = '0;
    pr_ancount = '0;
    pr_steps   = '0;
    pr_skip    = '0;
    pr_seen    = '0;
    pr_rtype   = '0;
    pr_rlen    = '0;
    pr_addr    = '0;
    pr_status  = ST_NO_A;
    pr_done    = 1'b0;
  endtask

  function automatic bit in_question(input phase_t ph);
    return ph inside {PH_HDR, PH_QNAME, PH_QLABEL, PH_QPTR, PH_QTAIL};
  endfunction

  task automatic settle(input status_t code);
    pr_done   = 1'b1;
    pr_status = code;
  endtask

  task automatic start_answer();
    int limit;
    limit = (int'(pr_ancount) < MAX_ANSWERS) ? int'(pr_ancount) : MAX_ANSWERS;
    if (int'(pr_seen) >= limit) begin
      settle(ST_NO_A);
    end else begin
      pr_seen  = pr_seen + 5'd1;
      pr_steps = '0;
      pr_phase = PH_ANAME;
    end
  endtask

  task automatic finish_name(input bit q);
    if (q) begin
      pr_phase = PH_QTAIL;
      pr_skip  = 16'd4;
    end else begin
      pr_phase = PH_AFIX;
      pr_skip  = 16'd10;
      pr_rtype = '0;
      pr_rlen  = '0;
    end
  endtask

  // one accepted word through the parse predictor
  task automatic dns_predict(input logic [7:0] b, input bit last,
                             output bit produced, output result_t res);
    bit q;
    int pos;
    produced = 1'b0;
    res = '0;
    if (int'(pr_off) < MAX_PACKET) begin
      if (!pr_done) begin
        q = in_question(pr_phase);
        case (pr_phase)
          PH_HDR: begin
            if (pr_off == 10'd2) pr_flags = {b, 8'h00};
            else if (pr_off == 10'd3) pr_flags = pr_flags | {8'h00, b};
            else if (pr_off == 10'd6) pr_ancount = {b, 8'h00};
            else if (pr_off == 10'd7) pr_ancount = pr_ancount | {8'h00, b};
            else if (pr_off == 10'd11) begin
              if (pr_flags[15] == 1'b0) settle(ST_NOT_RESP);
              else if (pr_flags[3:0] != 4'h0) settle(ST_RCODE);
              else if (pr_ancount == 16'd0) settle(ST_NO_ANS);
              else begin
                pr_phase = PH_QNAME;
                pr_steps = '0;
              end
            end
          end
          PH_QNAME, PH_ANAME: begin
            if (int'(pr_steps) > NAME_STEP_LIMIT) begin
              settle(q ? ST_BAD_NAME : ST_NO_A);
            end else begin
              pr_steps = pr_steps + 7'd1;
              if (b == 8'h00) finish_name(q);
              else if ((b & PTR_MASK) == PTR_MASK) pr_phase = q ? PH_QPTR : PH_APTR;
              else if ((b & PTR_MASK) != 8'h00) settle(q ? ST_BAD_NAME : ST_NO_A);
              else begin
                pr_skip  = {8'h00, b};
                pr_phase = q ? PH_QLABEL : PH_ALABEL;
              end
            end
          end
          PH_QLABEL, PH_ALABEL: begin
            pr_skip = pr_skip - 16'd1;
            if (pr_skip == 16'd0) pr_phase = q ? PH_QNAME : PH_ANAME;
          end
          PH_QPTR, PH_APTR: finish_name(q);
          PH_QTAIL, PH_ASKIP: begin
            pr_skip = pr_skip - 16'd1;
            if (pr_skip == 16'd0) start_answer();
          end
          PH_AFIX: begin
            pos = 10 - int'(pr_skip);
            if (pos == 0) pr_rtype = {b, 8'h00};
            else if (pos == 1) pr_rtype = pr_rtype | {8'h00, b};
            else if (pos == 8) pr_rlen = {b, 8'h00};
            else if (pos == 9) pr_rlen = pr_rlen | {8'h00, b};
            pr_skip = pr_skip - 16'd1;
            if (pr_skip == 16'd0) begin
              if (pr_rtype == 16'd1 && pr_rlen == 16'd4) begin
                pr_phase = PH_AADDR;
                pr_skip  = 16'd4;
                pr_addr  = '0;
              end else if (pr_rlen == 16'd0) begin
                start_answer();
              end else begin
                pr_skip  = pr_rlen;
                pr_phase = PH_ASKIP;
              end
            end
          end
          PH_AADDR: begin
            pr_addr = {pr_addr[23:0], b};
            pr_skip = pr_skip - 16'd1;
            if (pr_skip == 16'd0) settle(ST_FOUND);
          end
          default: ;
        endcase
      end
      pr_off = pr_off + 10'd1;
    end
    if (last) begin
      produced = 1'b1;
      if (pr_done) res.status = pr_status;
      else if (pr_phase == PH_HDR) res.status = ST_SHORT;
      else if (in_question(pr_phase)) res.status = ST_BAD_NAME;
      else res.status = ST_NO_A;
      res.ip_address = (res.status == ST_FOUND) ? pr_addr : '0;
      dns_reset_state();
    end
  endtask

  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic put_name(input name_form_t form, input int nlab, input int len);
    int n;
    repeat (nlab) begin
      if (len > 0) n = len;
      else n = ($urandom_range(0, 9) == 0) ? 63 : int'($urandom_range(1, 8));
      pkt.push_back(8'(n));
      repeat (n) pkt.push_back(8'($urandom));
    end
    case (form)
      NM_LABELS: pkt.push_back(8'h00);
      NM_PTR: begin
        pkt.push_back(8'hC0 | 8'($urandom_range(0, 63)));
        pkt.push_back(8'($urandom));
      end
      NM_RES01: pkt.push_back(8'h40 | 8'($urandom_range(0, 63)));
      default: pkt.push_back(8'h80 | 8'($urandom_range(0, 63)));
    endcase
  endtask

  task automatic put_record(input name_form_t form, input int nlab, input int len,
                            input logic [15:0] rtype, input logic [15:0] rlen,
                            input logic [31:0] ip);
    put_name(form, nlab, len);
    put16(rtype);
    put16(16'd1);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rlen);
    if (rtype == 16'd1 && rlen == 16'd4) begin
      put16(ip[31:16]);
      put16(ip[15:0]);
    end else begin
      repeat (int'(rlen)) pkt.push_back(8'($urandom));
    end
  endtask

  task automatic build_packet(input pkt_spec_t s);
    pkt.delete();
    put16(16'($urandom));
    put16(s.flags);
    put16(16'($urandom));
    put16(s.ancount);
    put16(16'($urandom));
    put16(16'($urandom));
    put_name(s.q_form, s.q_lab, s.lab_len);
    put16(16'd1);
    put16(16'd1);
    repeat (s.n_pre)
      put_record(NM_PTR, 0, s.lab_len, 16'($urandom_range(2, 300)),
                 16'($urandom_range(0, 6)), 32'h0);
    put_record(s.a_form, s.a_lab, s.lab_len, s.a_type, s.a_len, s.a_ip);
    repeat (s.n_post) put_record(NM_PTR, 0, s.lab_len, 16'd1, 16'd4, $urandom);
    if (s.trunc > 0) while (pkt.size() > s.trunc) void'(pkt.pop_back());
    repeat (s.pad) pkt.push_back(8'($urandom));
  endtask

  function automatic name_form_t pick_form();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return NM_RES01;
    if (r == 1) return NM_RES10;
    return (r < 11) ? NM_PTR : NM_LABELS;
  endfunction

  task automatic make_random_packet();
    pkt_spec_t s;
    int nrec;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes
      pkt.delete();
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
    end else begin
      s = '0;
      s.flags = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                              : (16'h8000 | (16'($urandom) & 16'h7FF0));
      s.q_form = pick_form();
      if ($urandom_range(0, 29) == 0) begin
        s.q_lab   = $urandom_range(63, 65);
        s.lab_len = 1;
      end else begin
        s.q_lab   = $urandom_range((s.q_form == NM_LABELS) ? 1 : 0, 4);
        s.lab_len = 0;
      end
      s.n_pre  = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 3);
      s.a_form = pick_form();
      s.a_lab  = $urandom_range((s.a_form == NM_LABELS) ? 1 : 0, 2);
      r = $urandom_range(0, 9);
      if (r < 7) s.a_type = 16'd1;
      else if (r < 9) s.a_type = 16'd28;
      else s.a_type = 16'($urandom);
      s.a_len  = ($urandom_range(0, 3) != 0) ? 16'd4 : 16'($urandom_range(0, 8));
      s.a_ip   = $urandom;
      s.n_post = $urandom_range(0, 2);
      nrec = s.n_pre + 1 + s.n_post;
      r = $urandom_range(0, 19);
      if (r < 2) s.ancount = 16'($urandom);
      else if (r == 2) s.ancount = 16'd0;
      else s.ancount = 16'(nrec + int'($urandom_range(0, 2)) - (($urandom_range(0, 4) == 0) ? 1 : 0));
      s.pad = ($urandom_range(0, 49) == 0) ? $urandom_range(500, 600) : $urandom_range(0, 2);
      build_packet(s);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(1, pkt.size());
        while (pkt.size() > r) void'(pkt.pop_back());
      end
    end
    // every word is offered, including those past the size limit
    live_words = pkt.size();
  endtask

  // offer one word; returns at the edge where it is taken
  task automatic send_word(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_packet_byte <= b;
    in_last_byte   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_packet(input bit typed, input status_t exp_st, input logic [31:0] exp_ip);
    bit produced;
    bit last;
    result_t res;
    foreach (pkt[k]) begin
      last = (k == pkt.size() - 1);
      send_word(pkt[k], last);
      dns_predict(pkt[k], last, produced, res);
      if (produced) begin
        if (typed) begin
          res.status     = exp_st;
          res.ip_address = (exp_st == ST_FOUND) ? exp_ip : '0;
        end
        expected_lookups.push_back(res);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lookups.size() == 0) begin
        $error("unexpected result: status %0d ip_address %08h", out_status, out_ip_address);
        error_count++;
      end else begin
        head_lookup = expected_lookups.pop_front();
        if (out_status !== head_lookup.status) begin
          $error("status: expected %0d, actual %0d", head_lookup.status, out_status);
          error_count++;
        end
        if (out_ip_address !== head_lookup.ip_address) begin
          $error("ip_address: expected %08h, actual %08h",
                 head_lookup.ip_address, out_ip_address);
          error_count++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin
    int rx_cycles;
    int span;
    int hold_left;
    rx_mode_t mode;
    logic [7:0] pat;
    rx_cycles = 0;
    span = 0;
    hold_left = 0;
    mode = RX_OPEN;
    pat = 8'h00;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 120);
          pat  = 8'($urandom);
        end
        span--;
        case (mode)
          RX_OPEN:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: begin
            out_stall <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int random_words;
    //          flags      ancount    q_form     q_lab len pre a_form     a_lab
    //          a_type     a_len      a_ip          post trunc pad typed status
    dir_tab = '{
      '{16'h8180, 16'd1,     NM_LABELS, 2,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'hC0A80001, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'hFFF0, 16'hFFFF,  NM_PTR,    0,  1,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'hFFFFFFFF, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'h8000, 16'd1,     NM_LABELS, 1,  63, 0,  NM_LABELS, 2,
        16'd1,    16'd4,     32'h00000000, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'h0100, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_NOT_RESP},
      '{16'h7FFF, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_NOT_RESP},
      '{16'h8183, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  3, 1'b1, ST_RCODE},
      '{16'hFFFF, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_RCODE},
      '{16'h8180, 16'd0,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_NO_ANS},
      '{16'h8180, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 1,  0, 1'b1, ST_SHORT},
      '{16'h8180, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 11, 0, 1'b1, ST_SHORT},
      '{16'h8180, 16'd1,     NM_LABELS, 1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 12, 0, 1'b1, ST_BAD_NAME},
      '{16'h8180, 16'd1,     NM_PTR,    0,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 16, 0, 1'b1, ST_BAD_NAME},
      '{16'h8180, 16'd1,     NM_RES01,  1,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_BAD_NAME},
      '{16'h8180, 16'd1,     NM_RES10,  0,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h01020304, 0, 0,  0, 1'b1, ST_BAD_NAME},
      '{16'h8180, 16'd1,     NM_LABELS, 64, 1,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h0A0B0C0D, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'h8180, 16'd1,     NM_LABELS, 65, 1,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h0A0B0C0D, 0, 0,  0, 1'b1, ST_BAD_NAME},
      '{16'h8180, 16'd1,     NM_PTR,    0,  3,  0,  NM_PTR,    0,
        16'd28,   16'd4,     32'h0A0B0C0D, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd1,     NM_PTR,    0,  3,  0,  NM_PTR,    0,
        16'd1,    16'd16,    32'h0A0B0C0D, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd3,     NM_PTR,    0,  3,  2,  NM_PTR,    0,
        16'd1,    16'd4,     32'h7F000001, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'h8180, 16'd2,     NM_PTR,    0,  3,  2,  NM_PTR,    0,
        16'd1,    16'd4,     32'h7F000001, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd16,    NM_PTR,    0,  3,  15, NM_PTR,    0,
        16'd1,    16'd4,     32'h08080808, 0, 0,  0, 1'b1, ST_FOUND},
      '{16'h8180, 16'd17,    NM_PTR,    0,  3,  16, NM_PTR,    0,
        16'd1,    16'd4,     32'h08080808, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd1,     NM_PTR,    0,  3,  0,  NM_RES10,  0,
        16'd1,    16'd4,     32'h08080808, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd1,     NM_PTR,    0,  1,  0,  NM_LABELS, 65,
        16'd1,    16'd4,     32'h08080808, 0, 0,  0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd1,     NM_PTR,    0,  3,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h08080808, 0, 25, 0, 1'b1, ST_NO_A},
      '{16'h8180, 16'd3,     NM_LABELS, 2,  0,  0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h11223344, 2, 0,  0, 1'b0, ST_FOUND},
      // question runs past the packet size limit
      '{16'h8180, 16'd1,     NM_LABELS, 9,  63, 0,  NM_PTR,    0,
        16'd1,    16'd4,     32'h11223344, 0, 0,  0, 1'b0, ST_FOUND}
    };
    dns_reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      build_packet(dir_tab[i]);
      send_packet(dir_tab[i].typed, dir_tab[i].exp_status, dir_tab[i].a_ip);
    end
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      make_random_packet();
      random_words += live_words;
      send_packet(1'b0, ST_FOUND, 32'h0);
    end
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[dns_response_a_record_parser_core.f]
rtl/core/dnsarp_pkg.sv
rtl/core/dnsarp_parser.sv
rtl/core/dns_response_a_record_parser_core.sv
test/dns_response_a_record_parser_core_tb.sv
